>>> sv/field_of_interest_window_extract_assert.svh
// ----------------------------------------------------------------------------
// Field-of-interest window extract: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIELD_OF_INTEREST_WINDOW_EXTRACT_ASSERT_SVH
`define FIELD_OF_INTEREST_WINDOW_EXTRACT_ASSERT_SVH

// same-cycle implication
`define FOWE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fowe assertion failed");

// next-cycle implication
`define FOWE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fowe assertion failed");

`endif

>>> sv/fowe_pkg.sv
// ----------------------------------------------------------------------------
// fowe_pkg
// Types and constants shared by the window extract modules.
// ----------------------------------------------------------------------------
package fowe_pkg;

	localparam int HITS_W     = 64;
	localparam int MAX_HALF   = 10;
	localparam int MAX_SPAN   = 2 * MAX_HALF + 1;
	localparam int WIN_W      = 63;
	localparam int LEN_W      = 6;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int HALF_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THREE_ROW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_COLUMNS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_ROWS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 3'd4;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [3:0]        row_number;
		logic [HITS_W-1:0] row_hits;
		logic [4:0]        seed_column;
		logic [3:0]        seed_row;
	} in_item_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_hits;
		logic [LEN_W-1:0] window_length;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_OUT
	} state_t;

endpackage

>>> sv/field_of_interest_window_extract.sv
// Load request: written into the table, and the block is ready again the next cycle.
// Extract request: ST_READ for one row group in single-row mode or three in three-row mode,
// then ST_DRAIN and ST_OUT, which registers the result once the output is free; one table row
// read per cycle in ST_READ via the row memory and shared segment unit; busy until ST_IDLE.
// Reset (arst_n low, async): control and config registers and row valid bits clear, table reads zero.
// ----------------------------------------------------------------------------
// field_of_interest_window_extract
// Hit row table with field-of-interest window extraction around a seed.
// ----------------------------------------------------------------------------
module field_of_interest_window_extract #(
	parameter int TABLE_ROWS    = 16,
	parameter int TABLE_COLUMNS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fowe_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fowe_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fowe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fowe_pkg::CFG_DATA_W-1:0] cfg_data
);

	import fowe_pkg::*;

	`include "field_of_interest_window_extract_assert.svh"

	localparam int RowAw = $clog2(TABLE_ROWS);

	// config
	logic [HALF_W-1:0] half_width_q;
	logic              three_row_q;
	logic [4:0]        pad_columns_q;
	logic              pad_rows_q;
	logic [4:0]        column_offset_q;

	// sequencer
	state_t             state_q, state_d;
	logic [1:0]         grp_q;
	logic               dv_s1;
	logic [COL_W-1:0]   x_q;
	logic [ROW_W-1:0]   y_q;
	logic [HALF_W-1:0]  w_q;
	logic               mode_q;
	logic [4:0]         span_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   off_q;
	logic [WIN_W-1:0]   acc_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic               in_acc;
	logic               ld_en;
	logic               ex_start;
	logic               rd_en;
	logic               last_grp;
	logic               out_load;
	logic [HALF_W-1:0]  w_sat;
	logic [4:0]         span_d;
	logic [6:0]         ld_row;
	logic [6:0]         rb;
	logic [6:0]         rd_row;
	logic               rd_ok;
	logic [TABLE_COLUMNS-1:0] rd_data;
	logic [MAX_SPAN-1:0] seg;
	logic [WIN_W-1:0]   placed;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign ld_row    = 7'(in_data.row_number);
	assign ld_en     = in_acc & (in_data.operation == OP_LOAD) & (int'(ld_row) < TABLE_ROWS);
	assign ex_start  = in_acc & (in_data.operation == OP_EXTRACT);

	assign w_sat  = (half_width_q > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_width_q;
	assign span_d = {w_sat, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q    <= '0;
			three_row_q     <= 1'b0;
			pad_columns_q   <= '0;
			pad_rows_q      <= 1'b0;
			column_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HALF_WIDTH:    half_width_q    <= cfg_data[HALF_W-1:0];
				CFG_THREE_ROW:     three_row_q     <= cfg_data[0];
				CFG_PAD_COLUMNS:   pad_columns_q   <= cfg_data;
				CFG_PAD_ROWS:      pad_rows_q      <= cfg_data[0];
				CFG_COLUMN_OFFSET: column_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// group order: centre row, row above, row below (biased by one)
	always_comb begin
		case (grp_q)
			2'd0:    rb = 7'(y_q) + 7'd1;
			2'd1:    rb = 7'(y_q);
			default: rb = 7'(y_q) + 7'd2;
		endcase
	end
	assign rd_row   = rb - 7'd1;
	assign rd_ok    = (rb != 7'd0) && (int'(rd_row) < TABLE_ROWS);
	assign last_grp = mode_q ? (grp_q == 2'd2) : (grp_q == 2'd0);
	assign out_load = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (ex_start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en = 1'b1;
				if (last_grp) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	fowe_row_mem #(
		.TABLE_ROWS    (TABLE_ROWS),
		.TABLE_COLUMNS (TABLE_COLUMNS)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ld_en),
		.wr_addr (ld_row[RowAw-1:0]),
		.wr_data (in_data.row_hits[TABLE_COLUMNS-1:0]),
		.rd_en   (rd_en),
		.rd_ok   (rd_ok),
		.rd_addr (rd_row[RowAw-1:0]),
		.rd_data (rd_data)
	);

	fowe_seg_unit u_seg (
		.row_bits   (HITS_W'(rd_data)),
		.col        (x_q),
		.half_width (w_q),
		.three_row  (mode_q),
		.seg        (seg)
	);

	assign placed = WIN_W'(seg) << off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grp_q       <= '0;
			dv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dv_s1   <= rd_en;
			if (ex_start) begin
				grp_q <= '0;
			end else if (rd_en) begin
				grp_q <= grp_q + 2'd1;
			end
			if (state_q == ST_OUT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ex_start) begin
			x_q    <= COL_W'(in_data.seed_column) + COL_W'(pad_columns_q)
			          + COL_W'(column_offset_q);
			y_q    <= ROW_W'(in_data.seed_row) + ROW_W'(pad_rows_q);
			w_q    <= w_sat;
			mode_q <= three_row_q;
			span_q <= span_d;
			len_q  <= three_row_q ? (LEN_W'(span_d) + {span_d, 1'b0}) : LEN_W'(span_d);
			off_q  <= '0;
			acc_q  <= '0;
		end else if (dv_s1) begin
			acc_q <= acc_q | placed;
			off_q <= off_q + LEN_W'(span_q);
		end
		if (state_q == ST_OUT && out_load) begin
			out_q.window_hits   <= acc_q;
			out_q.window_length <= len_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`FOWE_ASSERT_IMPL(a_hits_beyond_length_zero, out_valid, (out_data.window_hits >> out_data.window_length) == '0)
	`FOWE_ASSERT_IMPL(a_offset_matches_length, state_q == ST_OUT, off_q == len_q)
	`FOWE_ASSERT_IMPL(a_data_follows_read, dv_s1, $past(state_q) == ST_READ)

endmodule

>>> sv/fowe_row_mem.sv
// ----------------------------------------------------------------------------
// fowe_row_mem
// Hit row table: one write and one registered read per cycle, per-row valid
// bits so that rows never loaded read as zero.
// ----------------------------------------------------------------------------
module fowe_row_mem #(
	parameter int TABLE_ROWS    = 16,
	parameter int TABLE_COLUMNS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [$clog2(TABLE_ROWS)-1:0] wr_addr,
	input  logic [TABLE_COLUMNS-1:0]      wr_data,
	input  logic                          rd_en,
	input  logic                          rd_ok,
	input  logic [$clog2(TABLE_ROWS)-1:0] rd_addr,
	output logic [TABLE_COLUMNS-1:0]      rd_data
);

	logic [TABLE_COLUMNS-1:0] mem [TABLE_ROWS];
	logic [TABLE_ROWS-1:0]    valid_q;
	logic [TABLE_COLUMNS-1:0] rd_data_q;
	logic                     rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= rd_ok & valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

>>> sv/fowe_seg_unit.sv
// ----------------------------------------------------------------------------
// fowe_seg_unit
// Shared segment unit: cuts the field of interest out of one row word and
// orders it left to right or centre-out.
// ----------------------------------------------------------------------------
module fowe_seg_unit (
	input  logic [fowe_pkg::HITS_W-1:0]   row_bits,
	input  logic [fowe_pkg::COL_W-1:0]    col,
	input  logic [fowe_pkg::HALF_W-1:0]   half_width,
	input  logic                          three_row,
	output logic [fowe_pkg::MAX_SPAN-1:0] seg
);

	import fowe_pkg::*;

	localparam int ExtW = HITS_W + MAX_HALF;

	logic [ExtW-1:0]     ext;
	logic [ExtW-1:0]     shifted;
	logic [COL_W-1:0]    base;
	logic [MAX_SPAN-1:0] lr;
	logic [MAX_SPAN-1:0] span_mask;
	logic [MAX_SPAN-1:0] ord;
	logic [4:0]          w5;

	// ext bit i is column i - MAX_HALF
	assign ext     = {row_bits, {MAX_HALF{1'b0}}};
	assign base    = col + COL_W'(MAX_HALF) - COL_W'(half_width);
	assign shifted = ext >> base;
	assign lr      = shifted[MAX_SPAN-1:0];
	assign w5      = {1'b0, half_width};

	always_comb begin
		for (int i = 0; i < MAX_SPAN; i++) begin
			span_mask[i] = (5'(i) <= {half_width, 1'b0});
		end
		for (int j = 0; j < MAX_SPAN; j++) begin
			if (j == 0) begin
				ord[j] = lr[w5];
			end else if (j[0]) begin
				ord[j] = (5'((j + 1) >> 1) <= w5) ? lr[5'(w5 + 5'((j + 1) >> 1))] : 1'b0;
			end else begin
				ord[j] = (5'(j >> 1) <= w5) ? lr[5'(w5 - 5'(j >> 1))] : 1'b0;
			end
		end
	end

	assign seg = three_row ? (lr & span_mask) : ord;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the field-of-interest window extract against its own prediction of
// the hit table and window packing. A short table of directed requests is
// followed by phases of random loads and extracts under random burst/stall
// pacing, each phase with its own register setting.
// ----------------------------------------------------------------------------
module testbench;
	import fowe_pkg::*;

	localparam int TABLE_ROWS      = 16;
	localparam int TABLE_COLUMNS   = 64;
	localparam int NUM_PHASES      = 10;
	localparam int PHASE_REQUESTS  = 120;
	localparam int HOLD_PHASE      = 4;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;

	typedef enum logic [1:0] {
		STEP_SEND,
		STEP_FIXED,
		STEP_CFG
	} step_kind_t;

	typedef struct {
		step_kind_t               kind;
		logic [CFG_IDX_W-1:0]     cfg_idx;
		logic [CFG_DATA_W-1:0]    cfg_val;
		in_item_t                 req;
		out_item_t                fixed;
	} step_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	in_item_t              in_data    = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	// predicted block state
	logic [63:0] hit_table [TABLE_ROWS];
	logic [3:0]  half_width_q;
	logic        three_row_q;
	logic [4:0]  pad_columns_q;
	logic        pad_rows_q;
	logic [4:0]  column_offset_q;

	out_item_t   pending_windows[$];
	int          mismatch_count = 0;
	int          burst_left     = 0;
	bit          hold_request   = 1'b0;
	int unsigned cycle_count    = 0;

	field_of_interest_window_extract #(
		.TABLE_ROWS    (TABLE_ROWS),
		.TABLE_COLUMNS (TABLE_COLUMNS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic hit_at(input int r, input int c);
		if (r < 0 || r >= TABLE_ROWS || c < 0 || c >= TABLE_COLUMNS) begin
			return 1'b0;
		end
		return hit_table[r][c];
	endfunction

	function automatic out_item_t compute_window(input logic [4:0] sc, input logic [3:0] sr);
		out_item_t   res;
		int          half;
		int          cx;
		int          cy;
		int          span;
		int          rd;
		logic [63:0] acc;
		half = (int'(half_width_q) > MAX_HALF) ? MAX_HALF : int'(half_width_q);
		cx   = int'(sc) + int'(pad_columns_q) + int'(column_offset_q);
		cy   = int'(sr) + int'(pad_rows_q);
		span = 2 * half + 1;
		acc  = '0;
		if (!three_row_q) begin
			// centre, +1, -1, +2, -2, ...
			acc[0] = hit_at(cy, cx);
			for (int k = 1; k <= half; k++) begin
				acc[2*k-1] = hit_at(cy, cx + k);
				acc[2*k]   = hit_at(cy, cx - k);
			end
			res.window_length = LEN_W'(span);
		end else begin
			// centre row, row above, row below; each left to right
			for (int g = 0; g < 3; g++) begin
				rd = (g == 0) ? 0 : ((g == 1) ? -1 : 1);
				for (int k = 0; k < span; k++) begin
					acc[g*span+k] = hit_at(cy + rd, cx - half + k);
				end
			end
			res.window_length = LEN_W'(3 * span);
		end
		res.window_hits = acc[WIN_W-1:0];
		return res;
	endfunction

	function automatic in_item_t load_req(input logic [3:0] r, input logic [63:0] hits);
		in_item_t req;
		req.operation   = OP_LOAD;
		req.row_number  = r;
		req.row_hits    = hits;
		req.seed_column = 5'd23;
		req.seed_row    = 4'd15;
		return req;
	endfunction

	function automatic in_item_t extract_req(input logic [4:0] sc, input logic [3:0] sr);
		in_item_t req;
		req.operation   = OP_EXTRACT;
		req.row_number  = 4'd15;
		req.row_hits    = '1;
		req.seed_column = sc;
		req.seed_row    = sr;
		return req;
	endfunction

	function automatic step_t send_step(input in_item_t req);
		step_t s;
		s.kind    = STEP_SEND;
		s.cfg_idx = CFG_HALF_WIDTH;
		s.cfg_val = '0;
		s.req     = req;
		s.fixed   = '0;
		return s;
	endfunction

	function automatic step_t fixed_step(input in_item_t req, input logic [WIN_W-1:0] hits,
			input logic [LEN_W-1:0] len);
		step_t s;
		s = send_step(req);
		s.kind                = STEP_FIXED;
		s.fixed.window_hits   = hits;
		s.fixed.window_length = len;
		return s;
	endfunction

	function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		step_t s;
		s = send_step(extract_req(5'd0, 4'd0));
		s.kind    = STEP_CFG;
		s.cfg_idx = idx;
		s.cfg_val = val;
		return s;
	endfunction

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = $urandom_range(0, 10);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic offer_request(input in_item_t req, input bit use_fixed,
			input out_item_t fixed_win);
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		if (req.operation == OP_LOAD) begin
			hit_table[req.row_number] = req.row_hits;
		end else if (use_fixed) begin
			pending_windows.push_back(fixed_win);
		end else begin
			pending_windows.push_back(compute_window(req.seed_column, req.seed_row));
		end
		pace_sender();
	endtask

	// stop offering, wait for all windows, then let a trailing load finish
	task automatic settle_block();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_HALF_WIDTH:    half_width_q    = val[3:0];
			CFG_THREE_ROW:     three_row_q     = val[0];
			CFG_PAD_COLUMNS:   pad_columns_q   = val[4:0];
			CFG_PAD_ROWS:      pad_rows_q      = val[0];
			CFG_COLUMN_OFFSET: column_offset_q = val[4:0];
			default: ;
		endcase
	endtask

	// result side: checks accepted windows and drives its own stall pattern
	initial begin : result_side
		int        stall_mode;
		int        mode_left;
		int        hold_left;
		out_item_t want;
		stall_mode = 0;
		mode_left  = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_windows.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected window: hits %h len %0d",
							out_data.window_hits, out_data.window_length);
					end
				end else begin
					want = pending_windows.pop_front();
					if (out_data.window_hits !== want.window_hits ||
							out_data.window_length !== want.window_length) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("window mismatch: expected hits %h len %0d, got hits %h len %0d",
								want.window_hits, want.window_length,
								out_data.window_hits, out_data.window_length);
						end
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(10, 80);
				end
				mode_left--;
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((cycle_count % 5) != 0);
				endcase
			end
		end
	end

	initial begin : request_side
		step_t                 directed_steps[$];
		in_item_t              req;
		logic [CFG_DATA_W-1:0] setting [5];
		bit                    config_open;
		foreach (hit_table[r]) hit_table[r] = '0;
		half_width_q    = '0;
		three_row_q     = 1'b0;
		pad_columns_q   = '0;
		pad_rows_q      = 1'b0;
		column_offset_q = '0;
		config_open     = 1'b0;

		directed_steps = '{
			fixed_step(extract_req(5'd0, 4'd0), 63'd0, 6'd1),
			send_step(load_req(4'd0, '1)),
			send_step(load_req(4'd15, 64'h8000_0000_0000_0001)),
			fixed_step(extract_req(5'd0, 4'd0), 63'd1, 6'd1),
			fixed_step(extract_req(5'd23, 4'd15), 63'd0, 6'd1),
			fixed_step(extract_req(5'd0, 4'd15), 63'd1, 6'd1),
			cfg_step(CFG_HALF_WIDTH, 5'd15),
			cfg_step(CFG_PAD_COLUMNS, 5'd20),
			cfg_step(CFG_PAD_ROWS, 5'd1),
			cfg_step(CFG_COLUMN_OFFSET, 5'd20),
			cfg_step(CFG_THREE_ROW, 5'd0),
			send_step(load_req(4'd1, 64'hA5A5_3C3C_0FF0_F00F)),
			fixed_step(extract_req(5'd23, 4'd15), 63'd0, 6'd21),
			fixed_step(extract_req(5'd23, 4'd14), 63'd1, 6'd21),
			send_step(extract_req(5'd0, 4'd0)),
			send_step(extract_req(5'd11, 4'd0)),
			cfg_step(CFG_THREE_ROW, 5'd1),
			cfg_step(CFG_HALF_WIDTH, 5'd10),
			cfg_step(CFG_PAD_COLUMNS, 5'd0),
			cfg_step(CFG_PAD_ROWS, 5'd0),
			cfg_step(CFG_COLUMN_OFFSET, 5'd0),
			send_step(load_req(4'd5, '1)),
			fixed_step(extract_req(5'd10, 4'd5), 63'h1F_FFFF, 6'd63),
			send_step(extract_req(5'd0, 4'd0)),
			send_step(extract_req(5'd23, 4'd15)),
			send_step(extract_req(5'd5, 4'd6)),
			cfg_step(CFG_HALF_WIDTH, 5'd0),
			fixed_step(extract_req(5'd3, 4'd4), 63'd4, 6'd3),
			cfg_step(CFG_HALF_WIDTH, 5'd11),
			send_step(extract_req(5'd12, 4'd1)),
			send_step(load_req(4'd5, 64'd0)),
			fixed_step(extract_req(5'd10, 4'd5), 63'd0, 6'd63)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_CFG) begin
				if (!config_open) settle_block();
				write_register(directed_steps[i].cfg_idx, directed_steps[i].cfg_val);
				config_open = 1'b1;
			end else begin
				cfg_valid  <= 1'b0;
				config_open = 1'b0;
				offer_request(directed_steps[i].req, directed_steps[i].kind == STEP_FIXED,
					directed_steps[i].fixed);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_block();
			case (p)
				0: setting = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
				1: setting = '{5'd10, 5'd1, 5'd20, 5'd1, 5'd20};
				2: setting = '{5'd15, 5'd0, 5'd20, 5'd0, 5'd20};
				3: setting = '{5'd11, 5'd1, 5'd0, 5'd1, 5'd0};
				default: begin
					setting[0] = 5'($urandom_range(0, 15));
					setting[1] = 5'($urandom_range(0, 1));
					setting[2] = 5'($urandom_range(0, 20));
					setting[3] = 5'($urandom_range(0, 1));
					setting[4] = 5'($urandom_range(0, 20));
				end
			endcase
			write_register(CFG_HALF_WIDTH, setting[0]);
			write_register(CFG_THREE_ROW, setting[1]);
			write_register(CFG_PAD_COLUMNS, setting[2]);
			write_register(CFG_PAD_ROWS, setting[3]);
			write_register(CFG_COLUMN_OFFSET, setting[4]);
			cfg_valid <= 1'b0;
			if (p == HOLD_PHASE) hold_request = 1'b1;
			repeat (PHASE_REQUESTS) begin
				req.operation   = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_EXTRACT;
				req.row_number  = 4'($urandom_range(0, 15));
				req.seed_column = 5'($urandom_range(0, 23));
				req.seed_row    = 4'($urandom_range(0, 15));
				case ($urandom_range(0, 5))
					0: req.row_hits = '1;
					1: req.row_hits = '0;
					2: req.row_hits = 64'd1 << $urandom_range(0, 63);
					3: req.row_hits = {$urandom, $urandom} | {$urandom, $urandom};
					4: req.row_hits = {$urandom, $urandom} & {$urandom, $urandom};
					default: req.row_hits = {$urandom, $urandom};
				endcase
				offer_request(req, 1'b0, '0);
			end
		end

		settle_block();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/fowe_pkg.sv
sv/fowe_row_mem.sv
sv/fowe_seg_unit.sv
sv/field_of_interest_window_extract.sv
test/testbench.sv
